@@ rtl/scf_pkg.sv @@
`timescale 1ns / 1ps
package scf_pkg;

   localparam int QDEPTH = 4;
   localparam int QAW    = $clog2(QDEPTH);

   localparam logic [4:0] ACT_CONTROL   = 5'd0;
   localparam logic [4:0] ACT_SET_ANGLE = 5'd21;

   localparam logic [7:0]  MAX_ID_RESET = 8'd9;
   localparam logic [7:0]  ANGLE_MAX    = 8'd180;
   localparam logic [15:0] PULSE_BASE   = 16'd500;
   // 2000/180 scaled by 2^16, rounded up; exact floor for angles up to 180
   localparam logic [19:0] ANGLE_RECIP  = 20'd728178;

   localparam logic [2:0] ID_POW     = 3'd2;
   localparam logic [2:0] PARAM_MINW = 3'd4;

   localparam logic [7:0] CH_HASH = 8'h23;
   localparam logic [7:0] CH_BANG = 8'h21;
   localparam logic [7:0] CH_P    = 8'h50;
   localparam logic [7:0] CH_T    = 8'h54;
   localparam logic [7:0] CH_ZERO = 8'h30;

   typedef struct packed {
      logic [4:0]  action;
      logic [7:0]  id;
      logic [15:0] p1;
      logic [15:0] p2;
   } entry_type;

   typedef struct packed {
      logic [2:0][7:0] ch;
      logic [1:0]      len;
      logic [2:0]      width;
   } body_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_HASH,
      S_ID,
      S_P,
      S_TEXT,
      S_NUM1,
      S_T,
      S_NUM2,
      S_BANG
   } fsm_state_type;

   function automatic body_type mk_body(input logic [7:0] c0, input logic [7:0] c1,
                                        input logic [7:0] c2, input logic [1:0] len,
                                        input logic [2:0] width);
      body_type b;
      b.ch[0] = c0;
      b.ch[1] = c1;
      b.ch[2] = c2;
      b.len   = len;
      b.width = width;
      return b;
   endfunction

   function automatic body_type body_info(input logic [4:0] action);
      body_type b;
      unique case (action)
         5'd1:    b = mk_body("V", "E", "R", 2'd3, 3'd0);
         5'd2:    b = mk_body("I", "D", 8'h00, 2'd2, 3'd0);
         5'd3:    b = mk_body("I", "D", 8'h00, 2'd2, 3'd3);
         5'd4:    b = mk_body("U", "L", "K", 2'd3, 3'd0);
         5'd5:    b = mk_body("U", "L", "R", 2'd3, 3'd0);
         5'd6:    b = mk_body("M", "O", "D", 2'd3, 3'd0);
         5'd7:    b = mk_body("M", "O", "D", 2'd3, 3'd1);
         5'd8:    b = mk_body("R", "A", "D", 2'd3, 3'd0);
         5'd9:    b = mk_body("D", "P", "T", 2'd3, 3'd0);
         5'd10:   b = mk_body("D", "C", "T", 2'd3, 3'd0);
         5'd11:   b = mk_body("D", "S", "T", 2'd3, 3'd0);
         5'd12:   b = mk_body("B", "D", 8'h00, 2'd2, 3'd1);
         5'd13:   b = mk_body("S", "C", "K", 2'd3, 3'd0);
         5'd14:   b = mk_body("C", "S", "D", 2'd3, 3'd0);
         5'd15:   b = mk_body("C", "S", "M", 2'd3, 3'd0);
         5'd16:   b = mk_body("C", "S", "R", 2'd3, 3'd0);
         5'd17:   b = mk_body("S", "M", "I", 2'd3, 3'd0);
         5'd18:   b = mk_body("S", "M", "X", 2'd3, 3'd0);
         5'd19:   b = mk_body("C", "L", "E", 2'd3, 3'd0);
         5'd20:   b = mk_body("R", "T", "V", 2'd3, 3'd0);
         default: b = mk_body(8'h00, 8'h00, 8'h00, 2'd3, 3'd0);
      endcase
      return b;
   endfunction

   function automatic logic [16:0] pow10(input logic [2:0] p);
      logic [16:0] r;
      unique case (p)
         3'd0:    r = 17'd1;
         3'd1:    r = 17'd10;
         3'd2:    r = 17'd100;
         3'd3:    r = 17'd1000;
         3'd4:    r = 17'd10000;
         default: r = 17'd1;
      endcase
      return r;
   endfunction

   // decimal digit of rem at position p, rem below ten times that power
   function automatic logic [3:0] digit_at(input logic [15:0] rem, input logic [2:0] p);
      logic [3:0]  cnt;
      logic [16:0] step;
      cnt  = 4'd0;
      step = pow10(p);
      for (int j = 1; j < 10; j++) begin
         if ({1'b0, rem} >= 17'(j) * step) cnt = cnt + 4'd1;
      end
      return cnt;
   endfunction

   // position of the leading digit, at least minw digits
   function automatic logic [2:0] start_pow(input logic [15:0] v, input logic [2:0] minw);
      logic [2:0] nd;
      logic [2:0] mp;
      nd = 3'(v >= 16'd10) + 3'(v >= 16'd100) + 3'(v >= 16'd1000) + 3'(v >= 16'd10000);
      mp = (minw == 3'd0) ? 3'd0 : minw - 3'd1;
      return (nd > mp) ? nd : mp;
   endfunction

endpackage

@@ rtl/scf_front.sv @@
`timescale 1ns / 1ps
module scf_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [39:0]         req_tdata,
   input  logic [4:0]          req_tuser,
   input  logic                csr_wen,
   input  logic [7:0]          csr_wdata,
   input  logic                q_full,
   output logic                q_push,
   output scf_pkg::entry_type  q_entry
);
   import scf_pkg::*;

   logic [7:0]  max_id_ff;
   logic [7:0]  max_id_in;
   logic [7:0]  id;
   logic [15:0] p1;
   logic [15:0] p2;
   logic [7:0]  angle;
   logic [27:0] prod;
   logic        keep;

   assign id = req_tdata[7:0];
   assign p1 = req_tdata[23:8];
   assign p2 = req_tdata[39:24];

   assign max_id_in = csr_wen ? csr_wdata : max_id_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_id_ff <= MAX_ID_RESET;
      end else begin
         max_id_ff <= max_id_in;
      end
   end

   // angle to pulse width: 500 + angle * 2000 / 180
   assign angle = (p1 > {8'd0, ANGLE_MAX}) ? ANGLE_MAX : p1[7:0];
   assign prod  = 28'(angle) * 28'(ANGLE_RECIP);

   assign keep       = (id <= max_id_ff) && (req_tuser <= ACT_SET_ANGLE);
   assign req_tready = !q_full;
   assign q_push     = req_tvalid && req_tready && keep;

   always_comb begin
      q_entry.id = id;
      q_entry.p2 = p2;
      if (req_tuser == ACT_SET_ANGLE) begin
         q_entry.action = ACT_CONTROL;
         q_entry.p1     = PULSE_BASE + {4'd0, prod[27:16]};
      end else begin
         q_entry.action = req_tuser;
         q_entry.p1     = p1;
      end
   end

endmodule

@@ rtl/scf_queue.sv @@
`timescale 1ns / 1ps
module scf_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  scf_pkg::entry_type  push_entry,
   output logic                full,
   output logic                pop_valid,
   input  logic                pop,
   output scf_pkg::entry_type  pop_entry
);
   import scf_pkg::*;

   entry_type        mem_ff [QDEPTH];
   logic [QAW-1:0]   wr_ptr_ff;
   logic [QAW-1:0]   wr_ptr_in;
   logic [QAW-1:0]   rd_ptr_ff;
   logic [QAW-1:0]   rd_ptr_in;
   logic [QAW:0]     count_ff;
   logic [QAW:0]     count_in;
   logic             do_push;
   logic             do_pop;

   assign full      = (count_ff == (QAW+1)'(QDEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop_entry = mem_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && pop_valid;

   assign wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
   assign rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
   assign count_in  = count_ff + (QAW+1)'(do_push) - (QAW+1)'(do_pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

@@ rtl/scf_back.sv @@
`timescale 1ns / 1ps
module scf_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                q_valid,
   input  scf_pkg::entry_type  q_entry,
   output logic                q_pop,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [7:0]          rsp_tdata,
   output logic                rsp_tlast
);
   import scf_pkg::*;

   fsm_state_type state_ff;
   fsm_state_type state_in;
   entry_type     cur_ff;
   entry_type     cur_in;
   logic [15:0]   rem_ff;
   logic [15:0]   rem_in;
   logic [2:0]    pow_ff;
   logic [2:0]    pow_in;
   logic [1:0]    tix_ff;
   logic [1:0]    tix_in;
   logic          rsp_valid_ff;
   logic          rsp_valid_in;
   logic [7:0]    rsp_data_ff;
   logic [7:0]    rsp_data_in;
   logic          rsp_last_ff;
   logic          rsp_last_in;

   logic          adv;
   logic          emit;
   logic [7:0]    ch;
   logic          last;
   logic          is_ctrl;
   logic          text_end;
   body_type      body;
   logic [3:0]    digit;
   logic [16:0]   digit_sub;

   assign adv       = !rsp_valid_ff || rsp_tready;
   assign is_ctrl   = (cur_ff.action == ACT_CONTROL);
   assign body      = body_info(cur_ff.action);
   assign text_end  = (tix_ff == body.len - 2'd1);
   assign digit     = digit_at(rem_ff, pow_ff);
   assign digit_sub = 17'(digit) * pow10(pow_ff);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: if (q_valid) state_in = S_HASH;
         S_HASH: if (adv) state_in = S_ID;
         S_ID:   if (adv && pow_ff == 3'd0) state_in = S_P;
         S_P:    if (adv) state_in = is_ctrl ? S_NUM1 : S_TEXT;
         S_TEXT: if (adv && text_end) state_in = (body.width != 3'd0) ? S_NUM1 : S_BANG;
         S_NUM1: if (adv && pow_ff == 3'd0) state_in = is_ctrl ? S_T : S_BANG;
         S_T:    if (adv) state_in = S_NUM2;
         S_NUM2: if (adv && pow_ff == 3'd0) state_in = S_BANG;
         S_BANG: if (adv) state_in = q_valid ? S_HASH : S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      emit   = 1'b0;
      ch     = CH_ZERO;
      last   = 1'b0;
      q_pop  = 1'b0;
      cur_in = cur_ff;
      rem_in = rem_ff;
      pow_in = pow_ff;
      tix_in = tix_ff;
      unique case (state_ff)
         S_IDLE: begin
            q_pop = q_valid;
            if (q_valid) cur_in = q_entry;
         end
         S_HASH: begin
            if (adv) begin
               emit   = 1'b1;
               ch     = CH_HASH;
               rem_in = {8'd0, cur_ff.id};
               pow_in = ID_POW;
            end
         end
         S_P: begin
            if (adv) begin
               emit   = 1'b1;
               ch     = CH_P;
               tix_in = 2'd0;
               rem_in = cur_ff.p1;
               pow_in = start_pow(cur_ff.p1, PARAM_MINW);
            end
         end
         S_TEXT: begin
            if (adv) begin
               emit   = 1'b1;
               ch     = body.ch[tix_ff];
               tix_in = tix_ff + 2'd1;
               rem_in = cur_ff.p1;
               pow_in = start_pow(cur_ff.p1, body.width);
            end
         end
         S_T: begin
            if (adv) begin
               emit   = 1'b1;
               ch     = CH_T;
               rem_in = cur_ff.p2;
               pow_in = start_pow(cur_ff.p2, PARAM_MINW);
            end
         end
         S_ID, S_NUM1, S_NUM2: begin
            if (adv) begin
               emit   = 1'b1;
               ch     = CH_ZERO + {4'd0, digit};
               rem_in = 16'({1'b0, rem_ff} - digit_sub);
               pow_in = (pow_ff == 3'd0) ? pow_ff : pow_ff - 3'd1;
            end
         end
         S_BANG: begin
            if (adv) begin
               emit  = 1'b1;
               ch    = CH_BANG;
               last  = 1'b1;
               q_pop = q_valid;
               if (q_valid) cur_in = q_entry;
            end
         end
         default: begin
            emit = 1'b0;
         end
      endcase
   end

   assign rsp_valid_in = adv ? emit : rsp_valid_ff;
   assign rsp_data_in  = (adv && emit) ? ch : rsp_data_ff;
   assign rsp_last_in  = (adv && emit) ? last : rsp_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff      <= cur_in;
      rem_ff      <= rem_in;
      pow_ff      <= pow_in;
      tix_ff      <= tix_in;
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

@@ rtl/servo_ascii_command_framer.sv @@
`timescale 1ns / 1ps
// Turns each servo command request into its ASCII frame, "#" + three-digit id + "P" + body
// + "!", and sends it one byte per transfer with tlast on the closing "!". Requests with an
// id above the csr register (reset 9) or an action above 21 are taken and give no bytes; set
// angle (21) is clamped to 180 degrees and sent as a control frame with pulse
// 500 + angle*2000/180. A frame is 8 to 17 bytes, sent by the byte serializer one byte
// per cycle while rsp_tready allows; an empty serializer first picks up a request in its
// idle state. Up to four classified requests wait in a queue, so req_tready stays high
// while it has room and a following frame starts right after the previous "!".
module servo_ascii_command_framer (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // servo_id[7:0], param_first[23:8], param_second[39:24]
   input  logic [4:0]  req_tuser,   // action[4:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // tx_byte[7:0]
   output logic        rsp_tlast,
   input  logic        csr_wen,
   input  logic [7:0]  csr_wdata
);
   import scf_pkg::*;

   logic      q_full;
   logic      q_push;
   entry_type q_push_entry;
   logic      q_valid;
   logic      q_pop;
   entry_type q_pop_entry;

   scf_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .csr_wen    (csr_wen),
      .csr_wdata  (csr_wdata),
      .q_full     (q_full),
      .q_push     (q_push),
      .q_entry    (q_push_entry)
   );

   scf_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (q_push_entry),
      .full       (q_full),
      .pop_valid  (q_valid),
      .pop        (q_pop),
      .pop_entry  (q_pop_entry)
   );

   scf_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_valid),
      .q_entry    (q_pop_entry),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

@@ rtl/scf_checker.sv @@
`timescale 1ns / 1ps
module scf_assertions (
   input logic       clock,
   input logic       reset,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [7:0] rsp_tdata,
   input logic       rsp_tlast
);
   import scf_pkg::*;

   a_valid_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("rsp_tvalid dropped before transfer");

   a_data_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("rsp payload changed while stalled");

   a_last_is_bang: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tlast == (rsp_tdata == CH_BANG)))
      else $error("tlast not aligned with closing mark");

   a_frame_starts_hash: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && rsp_tlast |=> !rsp_tvalid || (rsp_tdata == CH_HASH))
      else $error("frame after tlast does not start with hash");

endmodule

bind servo_ascii_command_framer scf_assertions u_scf_assertions (.*);
